FILE: hw/rtl/point_in_triangle_barycentric_assert.svh
// Assertion macros for the barycentric point-in-triangle block.
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_ASSERT_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_ASSERT_SVH
`ifndef ASSERT_OFF
`define PIT_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PIT_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PIT_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define PIT_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/ptb_pkg.sv
// Shared constants for the barycentric point-in-triangle block.
package ptb_pkg;
    localparam int OUT_W = 24;
    localparam int QMAX = 26;
endpackage

FILE: hw/rtl/ptb_front.sv
// Front pipeline: edge vectors, dot products and exact numerators and denominator.
module ptb_front #(
    parameter int CW = 16,
    parameter int DW = 2 * CW + 4,
    parameter int NW = 2 * DW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_p [3],
    input  logic signed [CW-1:0] i_a [3],
    input  logic signed [CW-1:0] i_b [3],
    input  logic signed [CW-1:0] i_c [3],
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [NW-1:0] o_den,
    output logic signed [NW-1:0] o_nu,
    output logic signed [NW-1:0] o_nv
);
    import ptb_pkg::*;
    localparam int EW = CW + 1;

    logic [2:0] r_vld;
    logic       adv;
    logic signed [EW-1:0] r_e0 [3], r_e1 [3], r_w [3];
    logic signed [DW-1:0] r_d00, r_d01, r_d02, r_d11, r_d12;
    logic signed [NW-1:0] r_den, r_nu, r_nv;

    // The whole pipe moves when its last stage is free.
    assign adv     = !r_vld[2] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[2];
    assign o_den   = r_den;
    assign o_nu    = r_nu;
    assign o_nv    = r_nv;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Stage one: edge vectors.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_e0[k] <= EW'(i_c[k]) - EW'(i_a[k]);
                r_e1[k] <= EW'(i_b[k]) - EW'(i_a[k]);
                r_w[k]  <= EW'(i_p[k]) - EW'(i_a[k]);
            end
        end
    end

    // Stage two: five dot products.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d00 <= DW'(r_e0[0]*r_e0[0]) + DW'(r_e0[1]*r_e0[1]) + DW'(r_e0[2]*r_e0[2]);
            r_d01 <= DW'(r_e0[0]*r_e1[0]) + DW'(r_e0[1]*r_e1[1]) + DW'(r_e0[2]*r_e1[2]);
            r_d02 <= DW'(r_e0[0]*r_w[0]) + DW'(r_e0[1]*r_w[1]) + DW'(r_e0[2]*r_w[2]);
            r_d11 <= DW'(r_e1[0]*r_e1[0]) + DW'(r_e1[1]*r_e1[1]) + DW'(r_e1[2]*r_e1[2]);
            r_d12 <= DW'(r_e1[0]*r_w[0]) + DW'(r_e1[1]*r_w[1]) + DW'(r_e1[2]*r_w[2]);
        end
    end

    // Stage three: cross products of the dot products.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den <= NW'(r_d00 * r_d11) - NW'(r_d01 * r_d01);
            r_nu  <= NW'(r_d11 * r_d02) - NW'(r_d01 * r_d12);
            r_nv  <= NW'(r_d00 * r_d12) - NW'(r_d01 * r_d02);
        end
    end
endmodule

FILE: hw/rtl/ptb_queue.sv
// Two-entry queue between the front and back pipelines.
module ptb_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    import ptb_pkg::*;
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: hw/rtl/ptb_back.sv
// Back pipeline: classification and restoring division of both weights.
module ptb_back #(
    parameter int NW = 74,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [NW-1:0] i_den,
    input  logic signed [NW-1:0] i_nu,
    input  logic signed [NW-1:0] i_nv,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_inside,
    output logic [ptb_pkg::OUT_W-1:0] o_u,
    output logic [ptb_pkg::OUT_W-1:0] o_v,
    output logic                 o_degen
);
    import ptb_pkg::*;
    localparam int NS = QMAX - 1;        // stage 0 is the overflow check
    localparam int RW = NW + FB + QMAX;

    logic [NS:0]          r_vld;
    logic                 adv;
    logic [RW-1:0]        r_ru [NS+1], r_rv [NS+1];
    logic [NW-1:0]        r_d  [NS+1];
    logic [QMAX-1:0]      r_qu [NS+1], r_qv [NS+1];
    logic                 r_nu [NS+1], r_nvn [NS+1], r_ok [NS+1];
    logic                 r_in [NS+1], r_dg [NS+1];

    assign adv     = !r_vld[NS] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[NS-1:0], i_valid};
    end

    // Entry: magnitudes, flags and the saturation check on bit 25.
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] mu, mv;
        logic          pos;
        if (adv) begin
            pos = !i_den[NW-1] && (i_den != '0);
            mu  = i_nu[NW-1] ? NW'(-i_nu) : NW'(i_nu);
            mv  = i_nv[NW-1] ? NW'(-i_nv) : NW'(i_nv);
            r_ok[0]  <= pos;
            r_dg[0]  <= (i_den == '0);
            r_in[0]  <= pos && !i_nu[NW-1] && !i_nv[NW-1] &&
                        ((NW+1)'(i_nu) + (NW+1)'(i_nv) <= (NW+1)'(i_den));
            r_nu[0]  <= i_nu[NW-1];
            r_nvn[0] <= i_nv[NW-1];
            r_d[0]   <= i_den;
            r_ru[0]  <= RW'(mu) << FB;
            r_rv[0]  <= RW'(mv) << FB;
            r_qu[0]  <= ((RW'(mu) << FB) >= (RW'(i_den) << (QMAX-1)))
                        ? QMAX'(1) << (QMAX-1) : '0;
            r_qv[0]  <= ((RW'(mv) << FB) >= (RW'(i_den) << (QMAX-1)))
                        ? QMAX'(1) << (QMAX-1) : '0;
        end
    end

    // One quotient bit per stage, bit 24 down to bit 0.
    for (genvar s = 1; s <= NS; s++) begin : g_div
        localparam int B = QMAX - 1 - s;
        always_ff @(posedge i_clk) begin
            logic [RW-1:0] t;
            if (adv) begin
                t = RW'(r_d[s-1]) << B;
                r_d[s] <= r_d[s-1]; r_ok[s] <= r_ok[s-1]; r_dg[s] <= r_dg[s-1];
                r_in[s] <= r_in[s-1]; r_nu[s] <= r_nu[s-1]; r_nvn[s] <= r_nvn[s-1];
                r_ru[s] <= r_ru[s-1]; r_qu[s] <= r_qu[s-1];
                r_rv[s] <= r_rv[s-1]; r_qv[s] <= r_qv[s-1];
                if (!r_qu[s-1][QMAX-1] && r_ru[s-1] >= t) begin
                    r_ru[s] <= r_ru[s-1] - t;
                    r_qu[s] <= r_qu[s-1] | (QMAX'(1) << B);
                end
                if (!r_qv[s-1][QMAX-1] && r_rv[s-1] >= t) begin
                    r_rv[s] <= r_rv[s-1] - t;
                    r_qv[s] <= r_qv[s-1] | (QMAX'(1) << B);
                end
            end
        end
    end

    // Sign and saturation of the weights.
    function automatic logic [OUT_W-1:0] sat(input logic [QMAX-1:0] q, input logic n);
        logic [QMAX-1:0] lim;
        lim = n ? (QMAX'(1) << (OUT_W-1)) : ((QMAX'(1) << (OUT_W-1)) - QMAX'(1));
        if (q > lim) q = lim;
        return n ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    assign o_inside = r_in[NS];
    assign o_degen  = r_dg[NS];
    assign o_u      = r_ok[NS] ? sat(r_qu[NS], r_nu[NS]) : '0;
    assign o_v      = r_ok[NS] ? sat(r_qv[NS], r_nvn[NS]) : '0;
endmodule

FILE: hw/rtl/point_in_triangle_barycentric.sv
// Top level of the barycentric point-in-triangle test.
// channel | direction | handshake
// input   | in        | i_valid / o_ready, point and vertices
// result  | out       | o_valid / i_ready, inside, u, v, degenerate
// One item enters per cycle while o_ready is high; each result passes through
// 3 front stages, the queue, and 26 back stages.
// The back stages are an overflow check followed by one stage per quotient bit 24 to 0.
// Reset is synchronous and empties every pipeline stage and the queue.
// A stall at the output halts the back pipe; the front keeps going until the queue is full.
`include "point_in_triangle_barycentric_assert.svh"
module point_in_triangle_barycentric #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_p_x, i_p_y, i_p_z,
    input  logic signed [COORD_WIDTH-1:0] i_a_x, i_a_y, i_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_x, i_b_y, i_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_c_x, i_c_y, i_c_z,
    output logic o_valid,
    input  logic i_ready,
    output logic o_inside_res,
    output logic signed [ptb_pkg::OUT_W-1:0] o_u_coord,
    output logic signed [ptb_pkg::OUT_W-1:0] o_v_coord,
    output logic o_degenerate
);
    import ptb_pkg::*;
    localparam int DW = 2 * COORD_WIDTH + 4;
    localparam int NW = 2 * DW + 2;

    logic f_valid, f_ready, q_valid, q_ready;
    logic signed [NW-1:0] f_den, f_nu, f_nv;
    logic [3*NW-1:0] q_data;
    logic signed [COORD_WIDTH-1:0] p [3], a [3], b [3], c [3];

    assign p = '{i_p_x, i_p_y, i_p_z};
    assign a = '{i_a_x, i_a_y, i_a_z};
    assign b = '{i_b_x, i_b_y, i_b_z};
    assign c = '{i_c_x, i_c_y, i_c_z};

    ptb_front #(.CW(COORD_WIDTH), .DW(DW), .NW(NW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_p(p), .i_a(a), .i_b(b), .i_c(c),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_den(f_den), .o_nu(f_nu), .o_nv(f_nv)
    );

    ptb_queue #(.W(3*NW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready),
        .i_data({f_den, f_nu, f_nv}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    ptb_back #(.NW(NW), .FB(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready),
        .i_den(q_data[3*NW-1:2*NW]), .i_nu(q_data[2*NW-1:NW]), .i_nv(q_data[NW-1:0]),
        .o_valid, .i_ready,
        .o_inside(o_inside_res), .o_u(o_u_coord), .o_v(o_v_coord),
        .o_degen(o_degenerate)
    );

    // Checks on the result side.
    `PIT_ASSERT_IMPL(a_dg_out, i_clk, i_rst_n, o_valid && o_degenerate |-> !o_inside_res)
    `PIT_ASSERT_IMPL(a_dg_zero, i_clk, i_rst_n, o_valid && o_degenerate |-> o_u_coord == '0)
    `PIT_ASSERT_IMPL(a_in_pos, i_clk, i_rst_n, o_valid && o_inside_res |-> o_u_coord >= 0)
    `PIT_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)
endmodule
